// ===== design/dnsd_pkg.sv =====
package dnsd_pkg;

   // Default sizes of the message store and of the decoded name.
   localparam int MSG_BYTES_DEF      = 512;
   localparam int MAX_NAME_CHARS_DEF = 256;

   // Results per decode are bounded, which bounds the name at eight characters each.
   localparam int RESULT_CAP = 32;

   // Field widths of the transaction ports.
   localparam int ADDR_W    = 9;
   localparam int BYTE_W    = 8;
   localparam int CHARS_W   = 64;
   localparam int COUNT_W   = 4;
   localparam int OFFSET_W  = 9;
   localparam int HOPS_W    = 7;

   // Walk positions cover a 14-bit pointer target plus one label run.
   localparam int POS_W = 15;

   // Protocol constants of the name encoding.
   localparam logic [7:0] DOT_CHAR      = 8'h2E;
   localparam logic [1:0] PTR_TAG       = 2'b11;
   localparam logic [HOPS_W-1:0] HOPS_RESET = 7'd16;

   typedef enum logic {
      REQ_LOAD   = 1'b0,
      REQ_DECODE = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_HOPS  = 2'd1,
      STATUS_RANGE = 2'd2,
      STATUS_LONG  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_LEN,
      ST_LEN,
      ST_PTR,
      ST_CHAR,
      ST_DOT,
      ST_FINISH
   } state_type;

endpackage

// ===== design/dns_name_decompressor.sv =====
// DNS name decompressor.
// Input transactions are taken at a clock edge with start high and busy low.
// A load transaction (req_type 0) writes req_data_byte into the message
// memory at req_addr and gives no result; an address at or past MSG_BYTES
// is dropped. A decode transaction (req_type 1) walks the name at
// req_addr and returns it dotted, up to eight characters per result on the rsp_
// ports, each result marked by rsp_strobe for one cycle; the final one has
// rsp_last set, the offset past the name and a status.
// Walk: it uses the single registered read port of the message memory. A
// decode passes a read and a length state per length byte, a character
// state per label character, a dot state per dot, a pointer state per
// pointer and a closing state, after which the final result is registered.
// Busy is high for the whole walk; the next transaction is taken as it falls.
// The receiver cannot stall; results are never held back.
// csr_wr_en writes the pointer hop limit; write it only while idle.
// Reset is synchronous: the walk returns to idle, the hop limit goes to 16.
// The message memory is not cleared; decode only bytes that were loaded.
module dns_name_decompressor #(
   parameter int MSG_BYTES      = dnsd_pkg::MSG_BYTES_DEF,
   parameter int MAX_NAME_CHARS = dnsd_pkg::MAX_NAME_CHARS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_type,
   input  logic [dnsd_pkg::ADDR_W-1:0]    req_addr,
   input  logic [dnsd_pkg::BYTE_W-1:0]    req_data_byte,
   output logic                           rsp_strobe,
   output logic [dnsd_pkg::CHARS_W-1:0]   rsp_name_chars,
   output logic [dnsd_pkg::COUNT_W-1:0]   rsp_char_count,
   output logic                           rsp_last,
   output logic [dnsd_pkg::OFFSET_W-1:0]  rsp_next_offset,
   output logic [1:0]                     rsp_status,
   input  logic                           csr_wr_en,
   input  logic [dnsd_pkg::HOPS_W-1:0]    csr_wr_data
);
   import dnsd_pkg::*;

   localparam int AW       = $clog2(MSG_BYTES);
   localparam int CHAR_CAP = (MAX_NAME_CHARS < RESULT_CAP * 8) ? MAX_NAME_CHARS
                                                                 : RESULT_CAP * 8;
   localparam int NLEN_W   = $clog2(CHAR_CAP + 1);
   localparam logic [POS_W-1:0]  POS_LIMIT = POS_W'(MSG_BYTES);
   localparam logic [NLEN_W-1:0] NLEN_CAP  = NLEN_W'(CHAR_CAP);
   localparam logic [COUNT_W-1:0] PACK_FULL = COUNT_W'(8);

   // Message memory.
   logic [BYTE_W-1:0] msg_mem [MSG_BYTES];
   logic [BYTE_W-1:0] rdata_ff;
   logic [AW-1:0]     rd_addr;
   logic              mem_we;

   // Walk state.
   state_type          state_ff, state_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [POS_W-1:0]   resume_ff, resume_in;
   logic               seen_ff, seen_in;
   logic [HOPS_W-1:0]  hops_ff, hops_in;
   logic [CHARS_W-1:0] pack_ff, pack_in;
   logic [COUNT_W-1:0] pcount_ff, pcount_in;
   logic [NLEN_W-1:0]  nlen_ff, nlen_in;
   logic [BYTE_W-1:0]  len_ff, len_in;
   logic [BYTE_W-1:0]  idx_ff, idx_in;
   status_type         status_ff, status_in;
   logic [HOPS_W-1:0]  max_hops_ff;

   // Result registers.
   logic               rsp_strobe_ff, rsp_strobe_in;
   logic [CHARS_W-1:0] rsp_chars_ff, rsp_chars_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic               rsp_last_ff, rsp_last_in;
   logic [OFFSET_W-1:0] rsp_next_ff, rsp_next_in;
   status_type         rsp_status_ff, rsp_status_in;

   // Shared decode conditions.
   logic              accept;
   logic              load_ok;
   logic [POS_W-1:0]  pos_plus1;
   logic [POS_W-1:0]  char_next;
   logic              pos_oor, plus1_oor, char_next_oor;
   logic              is_ptr, is_end;
   logic              hop_fail, push_fail, pack_full, label_done;
   logic [BYTE_W-1:0] push_byte;

   assign accept    = start && !busy;
   assign load_ok   = (POS_W'(req_addr) < POS_LIMIT);
   assign mem_we    = accept && (req_type == REQ_LOAD) && load_ok;
   assign pos_plus1 = pos_ff + POS_W'(1);
   assign char_next = pos_ff + POS_W'(idx_ff) + POS_W'(1);
   assign pos_oor       = (pos_ff >= POS_LIMIT);
   assign plus1_oor     = (pos_plus1 >= POS_LIMIT);
   assign char_next_oor = (char_next >= POS_LIMIT);
   assign is_ptr     = (rdata_ff[7:6] == PTR_TAG);
   assign is_end     = (rdata_ff == '0);
   assign hop_fail   = (hops_ff >= max_hops_ff);
   assign push_fail  = (nlen_ff >= NLEN_CAP);
   assign pack_full  = (pcount_ff == PACK_FULL);
   assign label_done = (idx_ff == len_ff);
   assign push_byte  = (state_ff == ST_DOT) ? DOT_CHAR : rdata_ff;

   // Read address follows the walk step that needs the byte next cycle.
   always_comb begin
      case (state_ff)
         ST_LEN:  rd_addr = pos_plus1[AW-1:0];
         ST_CHAR: rd_addr = char_next[AW-1:0];
         default: rd_addr = pos_ff[AW-1:0];
      endcase
   end

   // Memory with one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         msg_mem[AW'(req_addr)] <= req_data_byte;
      end
      rdata_ff <= msg_mem[rd_addr];
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_type == REQ_DECODE)) state_in = ST_RD_LEN;
         end
         ST_RD_LEN: state_in = pos_oor ? ST_FINISH : ST_LEN;
         ST_LEN: begin
            if (is_end || plus1_oor) state_in = ST_FINISH;
            else if (is_ptr)         state_in = ST_PTR;
            else                     state_in = ST_CHAR;
         end
         ST_PTR: state_in = hop_fail ? ST_FINISH : ST_RD_LEN;
         ST_CHAR: begin
            if (push_fail)          state_in = ST_FINISH;
            else if (label_done)    state_in = ST_DOT;
            else if (char_next_oor) state_in = ST_FINISH;
            else                    state_in = ST_CHAR;
         end
         ST_DOT:    state_in = push_fail ? ST_FINISH : ST_RD_LEN;
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Datapath updates and result generation.
   always_comb begin
      pos_in        = pos_ff;
      resume_in     = resume_ff;
      seen_in       = seen_ff;
      hops_in       = hops_ff;
      pack_in       = pack_ff;
      pcount_in     = pcount_ff;
      nlen_in       = nlen_ff;
      len_in        = len_ff;
      idx_in        = idx_ff;
      status_in     = status_ff;
      rsp_strobe_in = 1'b0;
      rsp_chars_in  = rsp_chars_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_next_in   = rsp_next_ff;
      rsp_status_in = rsp_status_ff;
      case (state_ff)
         ST_IDLE: begin
            // A decode clears the walk state.
            pos_in    = POS_W'(req_addr);
            resume_in = POS_W'(req_addr);
            seen_in   = 1'b0;
            hops_in   = '0;
            pack_in   = '0;
            pcount_in = '0;
            nlen_in   = '0;
            status_in = STATUS_OK;
         end
         ST_RD_LEN: begin
            if (pos_oor) status_in = STATUS_RANGE;
         end
         ST_LEN: begin
            len_in = rdata_ff;
            idx_in = BYTE_W'(1);
            if (is_end) begin
               if (!seen_ff) resume_in = pos_plus1;
            end else if (plus1_oor) begin
               status_in = STATUS_RANGE;
            end
         end
         ST_PTR: begin
            if (hop_fail) begin
               status_in = STATUS_HOPS;
            end else begin
               hops_in = hops_ff + HOPS_W'(1);
               if (!seen_ff) resume_in = pos_ff + POS_W'(2);
               seen_in = 1'b1;
               pos_in  = POS_W'({len_ff[5:0], rdata_ff});
            end
         end
         ST_CHAR, ST_DOT: begin
            if (push_fail) begin
               status_in = STATUS_LONG;
            end else begin
               // A full buffer goes out only when the next character arrives.
               if (pack_full) begin
                  rsp_strobe_in = 1'b1;
                  rsp_chars_in  = pack_ff;
                  rsp_count_in  = PACK_FULL;
                  rsp_last_in   = 1'b0;
                  rsp_next_in   = '0;
                  rsp_status_in = STATUS_OK;
                  pack_in       = CHARS_W'(push_byte);
                  pcount_in     = COUNT_W'(1);
               end else begin
                  pack_in   = pack_ff | (CHARS_W'(push_byte) << {pcount_ff[2:0], 3'b000});
                  pcount_in = pcount_ff + COUNT_W'(1);
               end
               nlen_in = nlen_ff + NLEN_W'(1);
               if (state_ff == ST_DOT) begin
                  pos_in = pos_ff + POS_W'(len_ff) + POS_W'(1);
                  if (!seen_ff) resume_in = pos_ff + POS_W'(len_ff) + POS_W'(1);
               end else if (!label_done) begin
                  if (char_next_oor) status_in = STATUS_RANGE;
                  else idx_in = idx_ff + BYTE_W'(1);
               end
            end
         end
         ST_FINISH: begin
            rsp_strobe_in = 1'b1;
            rsp_chars_in  = pack_ff;
            rsp_count_in  = pcount_ff;
            rsp_last_in   = 1'b1;
            rsp_next_in   = (status_ff == STATUS_OK) ? resume_ff[OFFSET_W-1:0] : '0;
            rsp_status_in = status_ff;
         end
         default: begin
            status_in = status_ff;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
         max_hops_ff   <= HOPS_RESET;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_wr_en) max_hops_ff <= csr_wr_data;
      end
   end

   // Walk and result payload registers.
   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      resume_ff     <= resume_in;
      seen_ff       <= seen_in;
      hops_ff       <= hops_in;
      pack_ff       <= pack_in;
      pcount_ff     <= pcount_in;
      nlen_ff       <= nlen_in;
      len_ff        <= len_in;
      idx_ff        <= idx_in;
      status_ff     <= status_in;
      rsp_chars_ff  <= rsp_chars_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_next_ff   <= rsp_next_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_name_chars  = rsp_chars_ff;
   assign rsp_char_count  = rsp_count_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_next_offset = rsp_next_ff;
   assign rsp_status      = rsp_status_ff;

   // A final result only follows the closing step of a walk.
   a_last_after_finish: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |-> $past(state_ff == ST_FINISH))
      else $error("final result without a closing step");

   // Intermediate results always carry a full buffer and no status.
   a_partial_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |-> (rsp_char_count == PACK_FULL &&
                                     rsp_status_ff == STATUS_OK))
      else $error("intermediate result not full");

   // The pack buffer never holds more than eight characters during a walk.
   a_pack_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHAR || state_ff == ST_DOT) |-> (pcount_ff <= PACK_FULL))
      else $error("pack buffer overfilled");

   // The name never grows past its cap during a walk.
   a_name_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHAR || state_ff == ST_DOT) |-> (nlen_ff <= NLEN_CAP))
      else $error("name length beyond cap");

   // A label character step always lies within the current label.
   a_label_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHAR) |-> (idx_ff != '0 && idx_ff <= len_ff))
      else $error("label index out of label");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import dnsd_pkg::*;

   localparam int MSG_BYTES   = MSG_BYTES_DEF;
   localparam int NAME_CAP    = (MAX_NAME_CHARS_DEF < RESULT_CAP * 8) ?
                                MAX_NAME_CHARS_DEF : RESULT_CAP * 8;
   // Two images of the message memory: one follows the stimulus plan as it
   // is written, the other follows the transactions the block accepts.
   localparam int IMG_PLAN    = 0;
   localparam int IMG_DUT     = 1;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int SETTLE      = 8;

   typedef struct packed {
      logic                drain;
      req_kind_type        kind;
      logic [ADDR_W-1:0]   addr;
      logic [BYTE_W-1:0]   data;
   } dns_req_type;

   typedef struct packed {
      logic [CHARS_W-1:0]  chars;
      logic [COUNT_W-1:0]  count;
      logic                last;
      logic [OFFSET_W-1:0] next_ofs;
      status_type          status;
   } name_rsp_type;

   logic                clock         = 1'b0;
   logic                reset         = 1'b1;
   logic                start         = 1'b0;
   logic                busy;
   logic                req_type      = 1'b0;
   logic [ADDR_W-1:0]   req_addr      = '0;
   logic [BYTE_W-1:0]   req_data_byte = '0;
   logic                rsp_strobe;
   logic [CHARS_W-1:0]  rsp_name_chars;
   logic [COUNT_W-1:0]  rsp_char_count;
   logic                rsp_last;
   logic [OFFSET_W-1:0] rsp_next_offset;
   logic [1:0]          rsp_status;
   logic                csr_wr_en     = 1'b0;
   logic [HOPS_W-1:0]   csr_wr_data   = '0;

   // Pending transactions, expected results and the walk scratch state.
   dns_req_type    item_q[$];
   name_rsp_type   name_rsp_q[$];
   name_rsp_type   walk_res[$];
   int          walk_miss;
   logic [63:0] walk_pack;
   int          walk_count;
   int          walk_len;

   logic [7:0]  mem_img[2][MSG_BYTES];
   bit          loaded_img[2][MSG_BYTES];
   int          hop_img[2];
   int          name_starts[$];

   int          send_idle_pct = 17;
   bit          draining      = 1'b0;
   int          plan_items    = 0;
   int          plan_results  = 0;
   int          load_total    = 0;
   int          decode_total  = 0;
   int          result_total  = 0;
   int          mismatch_count = 0;
   int          status_seen[4];
   int          cycle_count   = 0;

   dns_name_decompressor dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_addr        (req_addr),
      .req_data_byte   (req_data_byte),
      .rsp_strobe      (rsp_strobe),
      .rsp_name_chars  (rsp_name_chars),
      .rsp_char_count  (rsp_char_count),
      .rsp_last        (rsp_last),
      .rsp_next_offset (rsp_next_offset),
      .rsp_status      (rsp_status),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always #1 clock = ~clock;

   // Prints one mismatch line and counts it.
   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("tb: mismatch in %s at result %0d: got %h, expected %h",
               what, result_total, got, want);
      mismatch_count++;
   endtask

   // Reads one byte of a memory image; a miss on an unloaded byte is noted.
   function automatic bit fetch_byte(int side, int a, output logic [7:0] v);
      v = 8'h00;
      if (a >= MSG_BYTES) return 1'b0;
      if (!loaded_img[side][a]) begin
         if (walk_miss < 0) walk_miss = a;
         return 1'b0;
      end
      v = mem_img[side][a];
      return 1'b1;
   endfunction

   function automatic void add_result(logic [63:0] chars, int count, logic last,
                                      int next_ofs, status_type status);
      name_rsp_type r;
      r.chars    = chars;
      r.count    = COUNT_W'(count);
      r.last     = last;
      r.next_ofs = OFFSET_W'(next_ofs);
      r.status   = status;
      walk_res.push_back(r);
   endfunction

   // Appends one character to the packed output; fails once the name is full.
   function automatic bit push_char(logic [7:0] c);
      if (walk_len >= NAME_CAP) return 1'b0;
      if (walk_count == 8) begin
         add_result(walk_pack, 8, 1'b0, 0, STATUS_OK);
         walk_pack  = '0;
         walk_count = 0;
      end
      walk_pack[8*walk_count +: 8] = c;
      walk_count++;
      walk_len++;
      return 1'b1;
   endfunction

   // Walks the name at start_pos in one memory image and leaves the
   // results it gives in walk_res.
   function automatic void decode_name(int side, int start_pos);
      int         pos, resume, hops, i, len;
      bit         ptr_seen, done;
      logic [7:0] b, b2, c;
      status_type st;
      walk_res.delete();
      walk_miss  = -1;
      walk_pack  = '0;
      walk_count = 0;
      walk_len   = 0;
      pos        = start_pos;
      resume     = start_pos;
      ptr_seen   = 1'b0;
      hops       = 0;
      st         = STATUS_OK;
      done       = 1'b0;
      while (!done) begin
         if (!fetch_byte(side, pos, b)) begin
            st   = STATUS_RANGE;
            done = 1'b1;
         end else if (b[7:6] == PTR_TAG) begin
            // Compression pointer: only the first one fixes the offset after the name.
            if (!fetch_byte(side, pos + 1, b2)) begin
               st   = STATUS_RANGE;
               done = 1'b1;
            end else if (hops >= hop_img[side]) begin
               st   = STATUS_HOPS;
               done = 1'b1;
            end else begin
               hops++;
               if (!ptr_seen) resume = pos + 2;
               ptr_seen = 1'b1;
               pos = int'({b[5:0], b2});
            end
         end else if (b == 8'h00) begin
            if (!ptr_seen) resume = pos + 1;
            done = 1'b1;
         end else begin
            // Plain label, including the reserved 01 and 10 length forms.
            len = int'(b);
            for (i = 1; i <= len && !done; i++) begin
               if (!fetch_byte(side, pos + i, c)) begin
                  st   = STATUS_RANGE;
                  done = 1'b1;
               end else if (!push_char(c)) begin
                  st   = STATUS_LONG;
                  done = 1'b1;
               end
            end
            if (!done && !push_char(DOT_CHAR)) begin
               st   = STATUS_LONG;
               done = 1'b1;
            end
            if (!done) begin
               pos += len + 1;
               if (!ptr_seen) resume = pos;
            end
         end
      end
      add_result(walk_pack, walk_count, 1'b1, (st == STATUS_OK) ? resume : 0, st);
   endfunction

   // Updates the block's image for one accepted transaction.
   function automatic void predict_request(logic kind, logic [ADDR_W-1:0] a,
                                           logic [BYTE_W-1:0] d);
      if (kind == REQ_LOAD) begin
         mem_img[IMG_DUT][a]    = d;
         loaded_img[IMG_DUT][a] = 1'b1;
         load_total++;
      end else begin
         decode_name(IMG_DUT, a);
         foreach (walk_res[i]) name_rsp_q.push_back(walk_res[i]);
         decode_total++;
      end
   endfunction

   task automatic queue_load(int a, logic [7:0] d);
      dns_req_type r;
      r.drain = 1'b0;
      r.kind  = REQ_LOAD;
      r.addr  = ADDR_W'(a);
      r.data  = d;
      item_q.push_back(r);
      mem_img[IMG_PLAN][a]    = d;
      loaded_img[IMG_PLAN][a] = 1'b1;
      plan_items++;
   endtask

   task automatic queue_drain();
      dns_req_type r;
      r       = '0;
      r.drain = 1'b1;
      item_q.push_back(r);
   endtask

   // Queues a decode; any byte the walk would read unloaded is loaded first.
   task automatic queue_decode(int a);
      dns_req_type r;
      int       sel;
      decode_name(IMG_PLAN, a);
      while (walk_miss >= 0) begin
         sel = $urandom_range(0, 9);
         if (sel < 3) queue_load(walk_miss, 8'h00);
         else if (sel < 7) queue_load(walk_miss, 8'($urandom_range(1, 8)));
         else queue_load(walk_miss, 8'($urandom_range(0, 255)));
         decode_name(IMG_PLAN, a);
      end
      r.drain = 1'b0;
      r.kind  = REQ_DECODE;
      r.addr  = ADDR_W'(a);
      r.data  = BYTE_W'($urandom_range(0, 255));
      item_q.push_back(r);
      plan_items++;
      plan_results += walk_res.size();
      if ($urandom_range(0, 9) == 0) queue_drain();
   endtask

   // Writes a well-formed name ending in a zero or a pointer, then decodes it.
   task automatic queue_name();
      int          nlab, total, base, pos, i, j;
      int          lens[4];
      bit          term_ptr;
      logic [13:0] tgt;
      nlab  = $urandom_range(1, 4);
      total = 0;
      for (i = 0; i < nlab; i++) begin
         lens[i] = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 63) : $urandom_range(1, 8);
         total += lens[i] + 1;
      end
      term_ptr = (name_starts.size() != 0) && ($urandom_range(0, 1) == 1);
      total += term_ptr ? 2 : 1;
      base = $urandom_range(0, MSG_BYTES - total);
      pos  = base;
      for (i = 0; i < nlab; i++) begin
         queue_load(pos, 8'(lens[i]));
         for (j = 1; j <= lens[i]; j++) queue_load(pos + j, 8'($urandom_range(0, 255)));
         pos += lens[i] + 1;
      end
      if (term_ptr) begin
         tgt = 14'(name_starts[$urandom_range(0, name_starts.size() - 1)]);
         queue_load(pos, {PTR_TAG, tgt[13:8]});
         queue_load(pos + 1, tgt[7:0]);
      end else begin
         queue_load(pos, 8'h00);
      end
      name_starts.push_back(base);
      queue_decode(base);
   endtask

   // Broken structures: pointer loops, pointers and labels past the end.
   task automatic queue_broken();
      int          len, base, j;
      logic [13:0] tgt;
      case ($urandom_range(0, 3))
         0: begin
            len  = $urandom_range(1, 7);
            base = $urandom_range(0, MSG_BYTES - (len + 3));
            tgt  = 14'(base);
            queue_load(base, 8'(len));
            for (j = 1; j <= len; j++) queue_load(base + j, 8'($urandom_range(0, 255)));
            queue_load(base + len + 1, {PTR_TAG, tgt[13:8]});
            queue_load(base + len + 2, tgt[7:0]);
            queue_decode(base);
         end
         1: begin
            base = $urandom_range(0, MSG_BYTES - 2);
            tgt  = 14'($urandom_range(MSG_BYTES, 16383));
            queue_load(base, {PTR_TAG, tgt[13:8]});
            queue_load(base + 1, tgt[7:0]);
            queue_decode(base);
         end
         2: begin
            len  = $urandom_range(0, 1) ? $urandom_range(1, 16) : $urandom_range(64, 191);
            base = MSG_BYTES - $urandom_range(1, (len < 8) ? len : 8);
            queue_load(base, 8'(len));
            queue_decode(base);
         end
         default: begin
            base = $urandom_range(0, MSG_BYTES - 2);
            tgt  = 14'(base);
            queue_load(base, {PTR_TAG, tgt[13:8]});
            queue_load(base + 1, tgt[7:0]);
            queue_decode(base);
         end
      endcase
   endtask

   // Random mix, mostly well-formed names, until both goals are met.
   task automatic plan_random(int item_goal, int result_goal);
      int item_end, result_end, sel;
      item_end   = plan_items + item_goal;
      result_end = plan_results + result_goal;
      while (plan_items < item_end || plan_results < result_end) begin
         sel = $urandom_range(0, 99);
         if (sel < 40) queue_name();
         else if (sel < 65 && name_starts.size() != 0)
            queue_decode(name_starts[$urandom_range(0, name_starts.size() - 1)]);
         else if (sel < 85) queue_decode($urandom_range(0, MSG_BYTES - 1));
         else queue_broken();
      end
   endtask

   task automatic plan_directed();
      // Root name at offset zero.
      queue_load(0, 8'h00);
      queue_decode(0);
      // One label followed by a pointer back to the root.
      queue_load(1, 8'd3);
      queue_load(2, 8'h77);
      queue_load(3, 8'h77);
      queue_load(4, 8'h77);
      queue_load(5, {PTR_TAG, 6'd0});
      queue_load(6, 8'h00);
      queue_decode(1);
      // A label that points to itself runs into the hop limit.
      queue_load(7, 8'd1);
      queue_load(8, 8'hFF);
      queue_load(9, {PTR_TAG, 6'd0});
      queue_load(10, 8'd7);
      queue_decode(7);
      // Pointer to the far end of the 14-bit space.
      queue_load(11, 8'hFF);
      queue_load(12, 8'hFF);
      queue_decode(11);
      // Reserved length byte at the top of memory, then a split pointer.
      queue_load(MSG_BYTES - 3, 8'h80);
      queue_load(MSG_BYTES - 2, DOT_CHAR);
      queue_load(MSG_BYTES - 1, {PTR_TAG, 6'd0});
      queue_decode(MSG_BYTES - 3);
      queue_decode(MSG_BYTES - 1);
      queue_drain();
   endtask

   // Waits until every pending transaction is taken and every result is in.
   task automatic wait_idle();
      while (item_q.size() != 0 || start || name_rsp_q.size() != 0 || busy)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_hops(int value);
      wait_idle();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= HOPS_W'(value);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      hop_img[IMG_PLAN] = value;
      hop_img[IMG_DUT]  = value;
   endtask

   // Driver: holds a transaction until it is taken, then issues the next one.
   always @(posedge clock) begin
      dns_req_type       nxt;
      logic              nxt_start;
      logic              nxt_type;
      logic [ADDR_W-1:0] nxt_addr;
      logic [BYTE_W-1:0] nxt_data;
      if (reset) begin
         start <= 1'b0;
      end else begin
         nxt_start = start;
         nxt_type  = req_type;
         nxt_addr  = req_addr;
         nxt_data  = req_data_byte;
         if (start && !busy) begin
            predict_request(req_type, req_addr, req_data_byte);
            nxt_start = 1'b0;
         end
         if (draining && name_rsp_q.size() == 0 && !busy) draining = 1'b0;
         if (!nxt_start && !draining && item_q.size() != 0 &&
             $urandom_range(0, 99) >= send_idle_pct) begin
            nxt = item_q.pop_front();
            if (nxt.drain) begin
               draining = 1'b1;
            end else begin
               nxt_start = 1'b1;
               nxt_type  = nxt.kind;
               nxt_addr  = nxt.addr;
               nxt_data  = nxt.data;
            end
         end
         start         <= nxt_start;
         req_type      <= nxt_type;
         req_addr      <= nxt_addr;
         req_data_byte <= nxt_data;
      end
   end

   // Monitor: every strobed result is checked against the oldest expectation.
   always @(posedge clock) begin
      name_rsp_type want;
      if (!reset && rsp_strobe) begin
         if (name_rsp_q.size() == 0) begin
            report_mismatch("unexpected result", rsp_name_chars, '0);
         end else begin
            want = name_rsp_q.pop_front();
            if (rsp_name_chars !== want.chars)
               report_mismatch("name_chars", rsp_name_chars, want.chars);
            if (rsp_char_count !== want.count)
               report_mismatch("char_count", 64'(rsp_char_count), 64'(want.count));
            if (rsp_last !== want.last)
               report_mismatch("last", 64'(rsp_last), 64'(want.last));
            if (rsp_next_offset !== want.next_ofs)
               report_mismatch("next_offset", 64'(rsp_next_offset), 64'(want.next_ofs));
            if (rsp_status !== want.status)
               report_mismatch("status", 64'(rsp_status), 64'(want.status));
            if (want.last) status_seen[want.status]++;
            result_total++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: timeout after %0d cycles, %0d results still expected",
                  cycle_count, name_rsp_q.size());
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      hop_img[IMG_PLAN] = int'(HOPS_RESET);
      hop_img[IMG_DUT]  = int'(HOPS_RESET);
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed cases run under the reset hop limit.
      plan_directed();

      write_hops(1);
      plan_random(75, 16);

      write_hops(127);
      send_idle_pct = 57;
      plan_random(75, 16);

      write_hops($urandom_range(2, 126));
      send_idle_pct = 0;
      plan_random(75, 16);

      write_hops(3);
      plan_random(75, 16);

      wait_idle();
      $display("tb: %0d load and %0d decode transactions, %0d results checked",
               load_total, decode_total, result_total);
      $display("tb: decodes ended ok %0d, hop limit %0d, out of range %0d, too long %0d",
               status_seen[STATUS_OK], status_seen[STATUS_HOPS],
               status_seen[STATUS_RANGE], status_seen[STATUS_LONG]);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
